// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the extended gcd / modular inverse unit.
// Depends on nothing; the including module provides clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside of reset.
`define EGM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EGM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/egm_pkg.sv =====
// Shared types and codes of the extended gcd / modular inverse unit.
// No dependencies.
package egm_pkg;

   localparam logic       OP_GCD             = 1'b0;
   localparam logic       OP_INVERSE         = 1'b1;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_DOMAIN      = 2'd1;
   localparam logic [1:0] STATUS_NOT_COPRIME = 2'd2;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== rtl/extended_gcd_modular_inverse.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   operation, first_operand, second_operand
// rsp       out        rsp_valid/rsp_ready   status, gcd, two coefficients, inverse
//
// Special cases go from PREP straight to FIN. Otherwise each Euclid step runs in the
// shared division unit (one quotient bit per cycle), with at most about 1.44*WIDTH
// Euclid steps per item.
// Reset is synchronous and clears the sequencer and the result valid flag.
// req_ready is high only in the idle state; a result stalled on rsp holds the
// sequencer in its final state until the output register is free.
// Depends on egm_pkg, egm_div_step and assert_macros.svh.
`include "assert_macros.svh"

module extended_gcd_modular_inverse #(
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic signed [WIDTH-1:0]  req_first_operand,
   input  logic signed [WIDTH-1:0]  req_second_operand,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [WIDTH-1:0]  rsp_gcd_value,
   output logic signed [WIDTH-1:0]  rsp_coeff_first,
   output logic signed [WIDTH-1:0]  rsp_coeff_second,
   output logic signed [WIDTH-1:0]  rsp_inverse_value
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_LOOP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam logic [WIDTH-1:0] ONE = {{(WIDTH-1){1'b0}}, 1'b1};

   logic [2:0]               state_ff, state_in;
   logic                     op_ff, op_in;
   logic signed [WIDTH-1:0]  a_ff, a_in;
   logic signed [WIDTH-1:0]  b_ff, b_in;
   logic                     swap_ff, swap_in;
   logic [WIDTH-1:0]         r0_ff, r0_in;
   logic [WIDTH-1:0]         r1_ff, r1_in;
   logic signed [WIDTH-1:0]  s0_ff, s0_in;
   logic signed [WIDTH-1:0]  s1_ff, s1_in;
   logic signed [WIDTH-1:0]  t0_ff, t0_in;
   logic signed [WIDTH-1:0]  t1_ff, t1_in;
   logic [1:0]               res_status_ff, res_status_in;
   logic [WIDTH-1:0]         res_gcd_ff, res_gcd_in;
   logic [WIDTH-1:0]         res_ca_ff, res_ca_in;
   logic [WIDTH-1:0]         res_cb_ff, res_cb_in;
   logic [WIDTH-1:0]         res_inv_ff, res_inv_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [WIDTH-1:0]         rsp_gcd_ff, rsp_gcd_in;
   logic [WIDTH-1:0]         rsp_ca_ff, rsp_ca_in;
   logic [WIDTH-1:0]         rsp_cb_ff, rsp_cb_in;
   logic [WIDTH-1:0]         rsp_inv_ff, rsp_inv_in;

   logic                     div_start;
   logic [WIDTH-2:0]         div_rem;
   logic signed [WIDTH:0]    div_sp;
   logic signed [WIDTH:0]    div_tp;
   egm_pkg::div_status_type  div_status;

   logic                     a_neg, b_neg, a_zero, b_zero, a_eq_b, a_lt_b;
   logic                     b_lt2, a_lt1, a_one;
   logic [WIDTH-1:0]         alpha, beta;
   logic [WIDTH:0]           s_next, t_next;

   egm_div_step #(
      .WIDTH(WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (r0_ff[WIDTH-2:0]),
      .divisor   (r1_ff),
      .s_factor  (s1_ff),
      .t_factor  (t1_ff),
      .remainder (div_rem),
      .s_product (div_sp),
      .t_product (div_tp),
      .status    (div_status)
   );

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      a_neg  = a_ff[WIDTH-1];
      b_neg  = b_ff[WIDTH-1];
      a_zero = (a_ff == '0);
      b_zero = (b_ff == '0);
      a_eq_b = (a_ff == b_ff);
      a_lt_b = (a_ff < b_ff);
      b_lt2  = b_neg || (b_ff[WIDTH-1:1] == '0);
      a_lt1  = a_neg || a_zero;
      a_one  = (a_ff == ONE);
      alpha  = swap_ff ? t0_ff : s0_ff;
      beta   = swap_ff ? s0_ff : t0_ff;
      s_next = {s0_ff[WIDTH-1], s0_ff} - div_sp;
      t_next = {t0_ff[WIDTH-1], t0_ff} - div_tp;

      state_in      = state_ff;
      op_in         = op_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      swap_in       = swap_ff;
      r0_in         = r0_ff;
      r1_in         = r1_ff;
      s0_in         = s0_ff;
      s1_in         = s1_ff;
      t0_in         = t0_ff;
      t1_in         = t1_ff;
      res_status_in = res_status_ff;
      res_gcd_in    = res_gcd_ff;
      res_ca_in     = res_ca_ff;
      res_cb_in     = res_cb_ff;
      res_inv_in    = res_inv_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_gcd_in    = rsp_gcd_ff;
      rsp_ca_in     = rsp_ca_ff;
      rsp_cb_in     = rsp_cb_ff;
      rsp_inv_in    = rsp_inv_ff;
      div_start     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_operation;
               a_in     = req_first_operand;
               b_in     = req_second_operand;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            res_status_in = egm_pkg::STATUS_OK;
            res_gcd_in    = '0;
            res_ca_in     = '0;
            res_cb_in     = '0;
            res_inv_in    = '0;
            state_in      = ST_FIN;
            // Euclid runs on the larger operand over the smaller one.
            swap_in = a_lt_b;
            r0_in   = a_lt_b ? b_ff : a_ff;
            r1_in   = a_lt_b ? a_ff : b_ff;
            s0_in   = ONE;
            s1_in   = '0;
            t0_in   = '0;
            t1_in   = ONE;
            if (op_ff == egm_pkg::OP_GCD) begin
               if (a_neg || b_neg || (a_zero && b_zero)) begin
                  res_status_in = egm_pkg::STATUS_DOMAIN;
                  res_gcd_in    = '1;
                  res_ca_in     = '1;
                  res_cb_in     = '1;
               end else if (a_eq_b) begin
                  res_gcd_in = a_ff;
                  res_ca_in  = ONE;
               end else begin
                  state_in = ST_LOOP;
               end
            end else begin
               if (b_lt2 || a_lt1) begin
                  res_status_in = egm_pkg::STATUS_DOMAIN;
                  res_inv_in    = '1;
               end else if (a_one) begin
                  res_inv_in = ONE;
               end else if (a_eq_b) begin
                  res_status_in = egm_pkg::STATUS_NOT_COPRIME;
                  res_inv_in    = '1;
               end else begin
                  state_in = ST_LOOP;
               end
            end
         end
         ST_LOOP: begin
            if (r1_ff == '0) begin
               state_in = ST_FIN;
               if (op_ff == egm_pkg::OP_GCD) begin
                  res_gcd_in = r0_ff;
                  res_ca_in  = alpha;
                  res_cb_in  = beta;
               end else if (r0_ff != ONE) begin
                  res_status_in = egm_pkg::STATUS_NOT_COPRIME;
                  res_inv_in    = '1;
               end else begin
                  // A coprime coefficient is above -b, so one add lifts it.
                  res_inv_in = alpha[WIDTH-1] ? alpha + b_ff : alpha;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               r0_in    = r1_ff;
               r1_in    = {1'b0, div_rem};
               s0_in    = s1_ff;
               s1_in    = s_next[WIDTH-1:0];
               t0_in    = t1_ff;
               t1_in    = t_next[WIDTH-1:0];
               state_in = ST_LOOP;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_gcd_in    = res_gcd_ff;
               rsp_ca_in     = res_ca_ff;
               rsp_cb_in     = res_cb_ff;
               rsp_inv_in    = res_inv_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      swap_ff       <= swap_in;
      r0_ff         <= r0_in;
      r1_ff         <= r1_in;
      s0_ff         <= s0_in;
      s1_ff         <= s1_in;
      t0_ff         <= t0_in;
      t1_ff         <= t1_in;
      res_status_ff <= res_status_in;
      res_gcd_ff    <= res_gcd_in;
      res_ca_ff     <= res_ca_in;
      res_cb_ff     <= res_cb_in;
      res_inv_ff    <= res_inv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_gcd_ff    <= rsp_gcd_in;
      rsp_ca_ff     <= rsp_ca_in;
      rsp_cb_ff     <= rsp_cb_in;
      rsp_inv_ff    <= rsp_inv_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_gcd_value     = rsp_gcd_ff;
   assign rsp_coeff_first   = rsp_ca_ff;
   assign rsp_coeff_second  = rsp_cb_ff;
   assign rsp_inverse_value = rsp_inv_ff;

   `EGM_ASSERT(a_div_busy_in_div, div_status.busy |-> state_ff == ST_DIV, "divider busy")
   `EGM_ASSERT(a_div_nonzero, state_ff == ST_DIV |-> r1_ff != '0, "division by zero")
   `EGM_ASSERT(a_done_in_div, div_status.done |-> state_ff == ST_DIV, "divider done outside DIV")
   `EGM_ASSERT_NEXT(a_accept_prep, req_valid && req_ready, state_ff == ST_PREP, "accept lost")

endmodule

// ===== rtl/egm_div_step.sv =====
// Shared iterative division unit for one Euclid step: one quotient bit per cycle.
// The quotient is never formed; it is folded into q*s and q*t products MSB first.
// Depends on egm_pkg.
module egm_div_step #(
   parameter int WIDTH = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [WIDTH-2:0]          dividend,
   input  logic [WIDTH-1:0]          divisor,
   input  logic signed [WIDTH-1:0]   s_factor,
   input  logic signed [WIDTH-1:0]   t_factor,
   output logic [WIDTH-2:0]          remainder,
   output logic signed [WIDTH:0]     s_product,
   output logic signed [WIDTH:0]     t_product,
   output egm_pkg::div_status_type   status
);

   localparam int CW = $clog2(WIDTH);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic [WIDTH-2:0]  num_ff, num_in;
   logic [WIDTH-2:0]  rem_ff, rem_in;
   logic [WIDTH:0]    sp_ff, sp_in;
   logic [WIDTH:0]    tp_ff, tp_in;

   logic [WIDTH-1:0]  trial;
   logic [WIDTH-1:0]  diff;
   logic              fits;
   logic [WIDTH:0]    s_ext;
   logic [WIDTH:0]    t_ext;

   always_comb begin
      trial = {rem_ff, num_ff[WIDTH-2]};
      fits  = trial >= divisor;
      diff  = trial - divisor;
      s_ext = {s_factor[WIDTH-1], s_factor};
      t_ext = {t_factor[WIDTH-1], t_factor};

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      sp_in   = sp_ff;
      tp_in   = tp_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         num_in  = dividend;
         rem_in  = '0;
         sp_in   = '0;
         tp_in   = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff - CW'(1);
         num_in = {num_ff[WIDTH-3:0], 1'b0};
         rem_in = fits ? diff[WIDTH-2:0] : trial[WIDTH-2:0];
         // Horner form of q*s: double the running product, add s where the bit is set.
         sp_in  = {sp_ff[WIDTH-1:0], 1'b0} + (fits ? s_ext : '0);
         tp_in  = {tp_ff[WIDTH-1:0], 1'b0} + (fits ? t_ext : '0);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      sp_ff  <= sp_in;
      tp_ff  <= tp_in;
   end

   assign remainder   = rem_ff;
   assign s_product   = sp_ff;
   assign t_product   = tp_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule
